### design/sbtp_pkg.sv
// Package for the single-bin tone power block: widths, sine polynomial constants,
// dB scaling constants and the shared front-to-back queue entry type.
// No dependencies.
package sbtp_pkg;

	localparam int unsigned DefMaxSamples   = 65536;
	localparam int unsigned DefTrigBits     = 10;
	localparam int unsigned SumW            = 50;
	localparam int unsigned LevelW          = 13;
	localparam logic [15:0] StepReset       = 16'd16384;
	localparam logic [31:0] SinA1           = 32'd1686629713;
	localparam logic [31:0] SinA3           = 32'd693598669;
	localparam logic [31:0] SinA5           = 32'd85569306;
	localparam logic [31:0] SinA7           = 32'd5026995;
	localparam logic [31:0] DbK             = 32'd3156528;
	localparam int          DbOffset        = 2192;
	localparam int          LevelFloor      = -4096;

	// one burst result request handed from the accumulator side to the level side
	typedef struct packed {
		logic [SumW-1:0] sum_re;
		logic [SumW-1:0] sum_im;
		logic [20:0]     count;
	} burst_t;

	// sine of r/16384 quarter turn, Q15; used only at elaboration to build a table
	function automatic logic [15:0] quarter_sine(input logic [14:0] r);
		logic [63:0] x, x2, t, s;
		begin
			x  = 64'(r) << 16;
			x2 = (x * x) >> 30;
			t  = 64'(SinA5) - ((x2 * 64'(SinA7)) >> 30);
			t  = 64'(SinA3) - ((x2 * t) >> 30);
			t  = 64'(SinA1) - ((x2 * t) >> 30);
			s  = (x * t) >> 30;
			s  = (s + 64'd16384) >> 15;
			if (s > 64'd32767)
				s = 64'd32767;
			return s[15:0];
		end
	endfunction

endpackage

### design/sbtp_if.sv
// Valid/ready channel interfaces for samples and results.
// Depends on sbtp_pkg for widths.
interface sbtp_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_re;
	logic signed [15:0] sample_im;
	logic               last_sample;
	modport source(output valid, sample_re, sample_im, last_sample, input ready);
	modport sink(input valid, sample_re, sample_im, last_sample, output ready);
endinterface

interface sbtp_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [sbtp_pkg::LevelW-1:0] level_db_sixteenths;
	logic                              zero_power;
	modport source(output valid, level_db_sixteenths, zero_power, input ready);
	modport sink(input valid, level_db_sixteenths, zero_power, output ready);
endinterface

### design/sbtp_front.sv
// Front part: sine/cosine table lookup, complex multiply and 50-bit accumulation.
// Depends on sbtp_pkg; pushes one burst_t per finished burst.
module sbtp_front #(
	parameter int unsigned MaxSamples = sbtp_pkg::DefMaxSamples,
	parameter int unsigned TrigBits   = sbtp_pkg::DefTrigBits
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [15:0]            step,
	input  logic                   smp_valid,
	output logic                   smp_ready,
	input  logic signed [15:0]     smp_re,
	input  logic signed [15:0]     smp_im,
	input  logic                   smp_last,
	output logic                   push,
	output sbtp_pkg::burst_t       push_data,
	input  logic                   q_full
);
	import sbtp_pkg::*;

	localparam int unsigned TabN = 1 << TrigBits;
	localparam int unsigned CntW = $clog2(MaxSamples + 1);

	// full-turn sine table at table resolution
	function automatic logic signed [16:0] rot_sine(input logic [15:0] a);
		logic [15:0] s;
		begin
			if (a[14])
				s = quarter_sine(15'(16384 - int'(a[13:0])));
			else
				s = quarter_sine({1'b0, a[13:0]});
			return a[15] ? -$signed({1'b0, s}) : $signed({1'b0, s});
		end
	endfunction

	logic signed [16:0] sin_tab [TabN];
	logic signed [16:0] cos_tab [TabN];
	for (genvar g = 0; g < TabN; g++) begin : g_tab
		localparam logic [15:0] Ang = 16'(g << (16 - TrigBits));
		assign sin_tab[g] = rot_sine(Ang);
		assign cos_tab[g] = rot_sine(16'(Ang + 16'd16384));
	end

	logic [15:0]           phase_q;
	logic [CntW-1:0]       count_q;
	logic signed [SumW-1:0] sre_q, sim_q;

	// stage 1: sample and rotator values registered
	logic                  v_s1, last_s1, acc_s1;
	logic signed [15:0]    re_s1, im_s1;
	logic signed [16:0]    sn_s1, cs_s1;
	// stage 2: products
	logic                  v_s2, last_s2, acc_s2;
	logic signed [33:0]    pr_s2, pi_s2;

	// hold off input while a burst end is in flight so its push always finds room
	assign smp_ready = !q_full && !(v_s1 && last_s1) && !(v_s2 && last_s2);

	logic take, room;
	assign take = smp_valid && smp_ready;
	assign room = count_q < CntW'(MaxSamples);

	logic [TrigBits-1:0] idx;
	assign idx = phase_q[15 -: TrigBits];

	// count and phase advance at accept time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			count_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			if (take) begin
				if (smp_last) begin
					phase_q <= '0;
					count_q <= '0;
				end else if (room) begin
					phase_q <= phase_q + step;
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	logic [20:0] cnt_s1, cnt_s2;
	always_ff @(posedge clk) begin
		if (take) begin
			re_s1   <= smp_re;
			im_s1   <= smp_im;
			sn_s1   <= sin_tab[idx];
			cs_s1   <= cos_tab[idx];
			last_s1 <= smp_last;
			acc_s1  <= room;
			cnt_s1  <= 21'(count_q) + 21'(room);
		end
		pr_s2   <= 34'(re_s1 * cs_s1) + 34'(im_s1 * sn_s1);
		pi_s2   <= 34'(im_s1 * cs_s1) - 34'(re_s1 * sn_s1);
		last_s2 <= last_s1;
		acc_s2  <= acc_s1;
		cnt_s2  <= cnt_s1;
	end

	logic signed [SumW-1:0] nre, nim;
	assign nre = acc_s2 ? sre_q + SumW'(pr_s2) : sre_q;
	assign nim = acc_s2 ? sim_q + SumW'(pi_s2) : sim_q;

	// accumulate; clear at burst end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sre_q <= '0;
			sim_q <= '0;
		end else if (v_s2) begin
			sre_q <= last_s2 ? '0 : nre;
			sim_q <= last_s2 ? '0 : nim;
		end
	end

	assign push             = v_s2 && last_s2;
	assign push_data.sum_re = nre;
	assign push_data.sum_im = nim;
	assign push_data.count  = cnt_s2;
endmodule

### design/sbtp_queue.sv
// Two-entry queue between the accumulator and the level unit.
// Depends on sbtp_pkg for burst_t.
module sbtp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sbtp_pkg::burst_t wdata,
	input  logic             pop,
	output sbtp_pkg::burst_t rdata,
	output logic             full,
	output logic             empty
);
	import sbtp_pkg::*;

	burst_t      mem_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

### design/sbtp_back.sv
// Back part: magnitude, normalize, log2 by repeated squaring, dB scaling.
// Depends on sbtp_pkg; sequencer takes one queue entry at a time.
module sbtp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  sbtp_pkg::burst_t              q_data,
	output logic                          pop,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic signed [sbtp_pkg::LevelW-1:0] res_level,
	output logic                          res_zero
);
	import sbtp_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_NORM  = 8'b0000_0010,
		S_SQ1   = 8'b0000_0100,
		S_SQ2   = 8'b0000_1000,
		S_LOGP  = 8'b0001_0000,
		S_LOGN  = 8'b0010_0000,
		S_SCALE = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t            state_q;
	logic [SumW-1:0]   a_q, b_q;
	logic [5:0]        k_q;
	logic [20:0]       n_q;
	logic [63:0]       pa_q;      // a*a, then P
	logic [63:0]       x_q;       // log argument
	logic [5:0]        e_q;
	logic [32:0]       m_q;
	logic [15:0]       frac_q;
	logic [4:0]        it_q;
	logic              second_q;  // log of N in progress
	logic signed [31:0] l_q;
	logic signed [63:0] u_q;
	logic [1:0]        sc_q;

	function automatic logic [SumW-1:0] mag(input logic [SumW-1:0] v);
		return v[SumW-1] ? -v : v;
	endfunction

	// leading-one position of a 64-bit word
	function automatic logic [5:0] lead(input logic [63:0] x);
		logic [5:0] e;
		begin
			e = '0;
			for (int i = 0; i < 64; i++)
				if (x[i])
					e = 6'(i);
			return e;
		end
	endfunction

	logic [65:0] msq;
	assign msq = 66'(m_q) * 66'(m_q);
	logic [34:0] mnext;
	assign mnext = msq[65:31] ;

	logic signed [31:0] logval;
	assign logval = {10'd0, e_q, frac_q};

	assign pop = (state_q == S_IDLE) && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			res_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						a_q      <= mag(q_data.sum_re);
						b_q      <= mag(q_data.sum_im);
						n_q      <= q_data.count;
						k_q      <= '0;
						second_q <= 1'b0;
						state_q  <= S_NORM;
					end
				end
				S_NORM: begin
					if (a_q == '0 && b_q == '0) begin
						res_level <= LevelW'(LevelFloor);
						res_zero  <= 1'b1;
						res_valid <= 1'b1;
						state_q   <= S_OUT;
					end else if (a_q[SumW-1:31] != '0 || b_q[SumW-1:31] != '0) begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
						k_q <= k_q + 1'b1;
					end else begin
						pa_q    <= 64'(a_q[30:0]) * 64'(a_q[30:0]);
						state_q <= S_SQ1;
					end
				end
				S_SQ1: begin
					pa_q    <= pa_q + 64'(b_q[30:0]) * 64'(b_q[30:0]);
					state_q <= S_SQ2;
				end
				S_SQ2: begin
					// choose the log2 argument x_q: the power sum first, then the sample count
					x_q     <= second_q ? 64'(n_q) : pa_q;
					state_q <= S_LOGP;
					it_q    <= 5'd31;
				end
				S_LOGP: begin
					if (it_q == 5'd31) begin
						e_q    <= lead(x_q);
						m_q    <= (lead(x_q) >= 6'd31) ? 33'(x_q >> (lead(x_q) - 6'd31))
							: 33'(x_q << (6'd31 - lead(x_q)));
						frac_q <= '0;
						it_q   <= '0;
					end else if (it_q != 5'd16) begin
						// square reaching 2.0 in Q31 gives a one bit and renormalizes
						if (mnext[32]) begin
							m_q    <= 33'(mnext >> 1);
							frac_q <= {frac_q[14:0], 1'b1};
						end else begin
							m_q    <= 33'(mnext);
							frac_q <= {frac_q[14:0], 1'b0};
						end
						it_q <= it_q + 1'b1;
					end else begin
						state_q <= S_LOGN;
					end
				end
				S_LOGN: begin
					if (!second_q) begin
						l_q      <= logval + 32'({k_q, 17'd0}) - (32'sd30 <<< 16);
						second_q <= 1'b1;
						state_q  <= S_SQ2;
					end else begin
						l_q     <= l_q - (logval <<< 1);
						sc_q    <= '0;
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					if (sc_q == 2'd0) begin
						u_q  <= 64'(l_q) * $signed({32'd0, DbK});
						sc_q <= 2'd1;
					end else begin
						u_q <= '0;
						if ((u_q + (64'sd1 <<< 46) + (64'sd1 <<< 31)) >>> 32
							< 64'sd16384 + DbOffset + LevelFloor)
							res_level <= LevelW'(LevelFloor);
						else if (((u_q + (64'sd1 <<< 46) + (64'sd1 <<< 31)) >>> 32)
							> 64'sd16384 + DbOffset)
							res_level <= '0;
						else
							res_level <= LevelW'(((u_q + (64'sd1 <<< 46) + (64'sd1 <<< 31))
								>>> 32) - 64'sd16384 - DbOffset);
						res_zero  <= 1'b0;
						res_valid <= 1'b1;
						state_q   <= S_OUT;
					end
				end
				S_OUT: begin
					if (res_ready) begin
						res_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### design/single_bin_tone_power_db_unit.sv
// Single-bin tone power meter. Samples are taken one per clock: a sine/cosine
// table lookup, a complex multiply and a 50-bit accumulate run in a pipeline of
// sample, product and accumulator registers. A sample marked last closes the
// burst; its sums go to a two-entry queue and the level unit computes 20*log10
// of the magnitude after taking the entry (normalize shifts, up to 19, two
// 16-step log2 squarings, one scale multiply), or skips to the output for a zero
// sum, then holds the result until it is taken. Samples flow on during that
// work; input stalls while a burst end is in flight and while the queue is full.
// Depends on sbtp_pkg, sbtp_if, sbtp_front, sbtp_queue, sbtp_back.
module single_bin_tone_power_db_unit #(
	parameter int unsigned MaxSamples = sbtp_pkg::DefMaxSamples,
	parameter int unsigned TrigBits   = sbtp_pkg::DefTrigBits
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata,
	sbtp_sample_if.sink   samples,
	sbtp_result_if.source results
);
	import sbtp_pkg::*;

	logic [15:0] step_q;
	// phase step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= StepReset;
		else if (cfg_we)
			step_q <= cfg_wdata;
	end

	logic   push, pop, full, empty;
	burst_t wdata, rdata;

	sbtp_front #(.MaxSamples(MaxSamples), .TrigBits(TrigBits)) u_front (
		.clk, .arst_n, .step(step_q),
		.smp_valid(samples.valid), .smp_ready(samples.ready),
		.smp_re(samples.sample_re), .smp_im(samples.sample_im),
		.smp_last(samples.last_sample),
		.push, .push_data(wdata), .q_full(full)
	);

	sbtp_queue u_queue (
		.clk, .arst_n, .push, .wdata, .pop, .rdata, .full, .empty
	);

	sbtp_back u_back (
		.clk, .arst_n, .q_empty(empty), .q_data(rdata), .pop,
		.res_valid(results.valid), .res_ready(results.ready),
		.res_level(results.level_db_sixteenths), .res_zero(results.zero_power)
	);
endmodule

### design/sbtp_checker.sv
// Port-level checker for the tone power unit, bound to the top level.
// Depends on nothing but the top-level ports.
module sbtp_props (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic signed [12:0]  level,
	input logic                zero
);
	// a zero sum always reports the floor
	a_zero_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero |-> level == -4096) else $error("zero without floor");
	// level never positive
	a_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(level > 13'sd0)) else $error("positive level");
	// result holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level) && $stable(zero))
		else $error("result dropped");
endmodule

bind single_bin_tone_power_db_unit sbtp_props u_chk (
	.clk, .arst_n, .out_valid(results.valid), .out_ready(results.ready),
	.level(results.level_db_sixteenths), .zero(results.zero_power)
);

### test/sbtp_checker.sv
// Checker for the single-bin tone power block: watches the sample, result and
// register ports, predicts each burst level and compares it with the result.
// Depends on sbtp_pkg and sbtp_if.
module sbtp_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata,
	sbtp_sample_if        smp,
	sbtp_result_if        res,
	output int            errors,
	output int            pending
);
	import sbtp_pkg::*;

	localparam int unsigned SampleCap = DefMaxSamples;
	localparam logic [15:0] AngleMask = 16'hFFFF << (16 - DefTrigBits);

	typedef struct {
		logic signed [LevelW-1:0] level;
		logic                     zero;
	} level_t;

	level_t           levels_due[$];
	logic [15:0]      step_q;
	logic [15:0]      phase_q;
	logic [SumW-1:0]  acc_re_q;
	logic [SumW-1:0]  acc_im_q;
	int unsigned      count_q;

	// Q15 sine over a quarter turn, odd polynomial in Q30
	function automatic longint quarter_sin(longint unsigned r);
		longint unsigned x, x2, t, s;
		x  = r << 16;
		x2 = (x * x) >> 30;
		t  = 64'(SinA5) - ((x2 * 64'(SinA7)) >> 30);
		t  = 64'(SinA3) - ((x2 * t) >> 30);
		t  = 64'(SinA1) - ((x2 * t) >> 30);
		s  = (x * t) >> 30;
		s  = (s + 64'd16384) >> 15;
		if (s > 64'd32767)
			s = 64'd32767;
		return longint'(s);
	endfunction

	function automatic longint rot_sin(logic [15:0] ang);
		longint v;
		v = ang[14] ? quarter_sin(16384 - ang[13:0]) : quarter_sin(ang[13:0]);
		return ang[15] ? -v : v;
	endfunction

	function automatic longint unsigned mag50(logic [SumW-1:0] v);
		logic [SumW-1:0] n;
		n = -v;
		return v[SumW-1] ? 64'(n) : 64'(v);
	endfunction

	// leading-bit exponent plus 16 fraction bits by repeated squaring
	function automatic longint log2_fix(longint unsigned x);
		int               e;
		longint unsigned  m;
		longint unsigned  frac;
		e = 63;
		frac = 0;
		while (e > 0 && !x[e])
			e--;
		m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		return (longint'(e) <<< 16) + longint'(frac);
	endfunction

	function automatic level_t burst_level(logic [SumW-1:0] sre, logic [SumW-1:0] sim,
			int unsigned n);
		level_t          r;
		longint unsigned a, b, u;
		longint          k, l, lv;
		a = mag50(sre);
		b = mag50(sim);
		if (a == 0 && b == 0) begin
			r.level = LevelW'(LevelFloor);
			r.zero  = 1'b1;
			return r;
		end
		k = 0;
		while (a >= 64'h8000_0000 || b >= 64'h8000_0000) begin
			a = a >> 1;
			b = b >> 1;
			k++;
		end
		l = log2_fix(a * a + b * b) + (k <<< 17) - 2 * log2_fix(64'(n)) - (64'sd30 <<< 16);
		u = longint'(l * longint'(DbK) + (64'sd1 <<< 46) + (64'sd1 <<< 31));
		lv = longint'(u >> 32) - (64'sd1 <<< 14) - DbOffset;
		if (lv < LevelFloor)
			lv = LevelFloor;
		if (lv > 0)
			lv = 0;
		r.level = LevelW'(lv);
		r.zero  = 1'b0;
		return r;
	endfunction

	assign pending = levels_due.size();

	// predict on every sample transfer, compare on every result transfer
	always @(posedge clk or negedge arst_n) begin
		longint   s, c, pr, pi;
		level_t   exp_l;
		if (!arst_n) begin
			step_q   <= StepReset;
			phase_q  <= '0;
			acc_re_q <= '0;
			acc_im_q <= '0;
			count_q  <= 0;
			errors   <= 0;
			levels_due.delete();
		end else begin
			if (cfg_we)
				step_q <= cfg_wdata;
			if (smp.valid && smp.ready) begin
				logic [SumW-1:0] nre, nim;
				int unsigned     ncnt;
				nre = acc_re_q;
				nim = acc_im_q;
				ncnt = count_q;
				if (count_q < SampleCap) begin
					s  = rot_sin(phase_q & AngleMask);
					c  = rot_sin((phase_q & AngleMask) + 16'd16384);
					pr = longint'(smp.sample_re) * c + longint'(smp.sample_im) * s;
					pi = longint'(smp.sample_im) * c - longint'(smp.sample_re) * s;
					nre = acc_re_q + SumW'(pr);
					nim = acc_im_q + SumW'(pi);
					ncnt = count_q + 1;
					phase_q <= phase_q + step_q;
				end
				if (smp.last_sample) begin
					levels_due.push_back(burst_level(nre, nim, ncnt));
					phase_q  <= '0;
					acc_re_q <= '0;
					acc_im_q <= '0;
					count_q  <= 0;
				end else begin
					acc_re_q <= nre;
					acc_im_q <= nim;
					count_q  <= ncnt;
				end
			end
			if (res.valid && res.ready) begin
				if (levels_due.size() == 0) begin
					$display("%0t: unexpected result level=%0d zero=%0b", $time,
						res.level_db_sixteenths, res.zero_power);
					errors <= errors + 1;
				end else begin
					exp_l = levels_due.pop_front();
					if (res.level_db_sixteenths !== exp_l.level
							|| res.zero_power !== exp_l.zero) begin
						$display("%0t: mismatch expected level=%0d zero=%0b actual level=%0d zero=%0b",
							$time, exp_l.level, exp_l.zero, res.level_db_sixteenths,
							res.zero_power);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

### test/tb.sv
// Testbench top for the single-bin tone power block: clock, reset, register
// writes, burst stimulus with idling phases, and the verdict.
// Depends on sbtp_pkg, sbtp_if, sbtp_checker and the block itself.
module tb;
	import sbtp_pkg::*;

	localparam int unsigned CycleLimit = 3000000;
	localparam int          DrainWait  = 200;

	typedef enum int {
		K_FULL,
		K_ZERO,
		K_SMALL,
		K_CONST,
		K_EXTREME
	} kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	int          errors;
	int          pending;
	int          idle_pct = 0;
	int          stall_pct = 0;
	logic        hold_req = 1'b0;
	longint      cycles = 0;

	sbtp_sample_if smp();
	sbtp_result_if res();

	single_bin_tone_power_db_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.samples(smp), .results(res)
	);

	sbtp_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.smp(smp), .res(res), .errors(errors), .pending(pending)
	);

	always #4 clk = ~clk;

	// result side: random stalls plus a long hold-off on request
	always @(posedge clk) begin
		int   hold_cnt;
		logic hold_seen;
		if (hold_req && !hold_seen)
			hold_cnt = 600;
		hold_seen = hold_req;
		if (hold_cnt > 0) begin
			hold_cnt--;
			res.ready <= 1'b0;
		end else
			res.ready <= ($urandom_range(99) >= stall_pct);
	end

	// timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send(logic [15:0] re, logic [15:0] im, logic last);
		while ($urandom_range(99) < idle_pct) begin
			smp.valid <= 1'b0;
			@(posedge clk);
		end
		smp.valid       <= 1'b1;
		smp.sample_re   <= re;
		smp.sample_im   <= im;
		smp.last_sample <= last;
		do @(posedge clk); while (!smp.ready);
	endtask

	task automatic burst(int len, kind_t kind);
		logic [15:0] re, im, c_re, c_im;
		c_re = 16'($urandom);
		c_im = 16'($urandom);
		for (int i = 0; i < len; i++) begin
			case (kind)
				K_FULL: begin
					re = 16'($urandom);
					im = 16'($urandom);
				end
				K_ZERO: begin
					re = '0;
					im = '0;
				end
				K_SMALL: begin
					re = 16'($signed($urandom_range(8)) - 4);
					im = 16'($signed($urandom_range(8)) - 4);
				end
				K_CONST: begin
					re = c_re;
					im = c_im;
				end
				default: begin
					re = $urandom_range(1) ? 16'h7FFF : 16'h8000;
					im = $urandom_range(1) ? 16'h7FFF : 16'h8000;
				end
			endcase
			send(re, im, i == len - 1);
		end
	endtask

	task automatic quiesce();
		smp.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DrainWait) @(posedge clk);
	endtask

	task automatic write_step(logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [15:0] steps [6] = '{16'd16384, 16'd0, 16'hFFFF, 16'd1, 16'd4096, 16'd0};
		int          items;
		smp.valid = 1'b0;
		smp.sample_re = '0;
		smp.sample_im = '0;
		smp.last_sample = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset step, extremes, zero sum, single-sample burst
		send(16'h7FFF, 16'h7FFF, 1'b1);
		send(16'h8000, 16'h8000, 1'b1);
		send(16'h0000, 16'h0000, 1'b1);
		send(16'h7FFF, 16'h8000, 1'b0);
		send(16'h8000, 16'h7FFF, 1'b1);
		burst(4, K_ZERO);
		burst(6, K_EXTREME);
		send(16'h0001, 16'h0000, 1'b1);
		quiesce();
		// step zero: a sample and its negation cancel exactly
		write_step(16'd0);
		send(16'h1234, 16'hFEDC, 1'b0);
		send(16'hEDCC, 16'h0124, 1'b1);
		quiesce();

		// random phases across idling modes and register settings
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 64; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 64; end
				default: begin idle_pct = 21; stall_pct = 21; end
			endcase
			write_step(ph < 6 ? steps[ph] : 16'($urandom));
			if (ph == 4)
				hold_req <= 1'b1;
			items = 0;
			while (items < 100) begin
				int    len;
				kind_t kind;
				len  = ($urandom_range(9) == 0) ? $urandom_range(64, 200)
					: $urandom_range(1, 12);
				kind = $urandom_range(9) < 6 ? K_FULL : kind_t'($urandom_range(1, 4));
				burst(len, kind);
				items += len;
			end
			hold_req <= 1'b0;
			quiesce();
		end

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
